// ===== rtl/shabs_pkg.sv =====
// Shared types, codes, constants and round functions for the SHA-256 byte stream hasher.
// No dependencies; used by shabs_core and sha256_byte_stream_hasher.
package shabs_pkg;

  localparam logic [1:0] MODE_ABSORB     = 2'd0;
  localparam logic [1:0] MODE_ABSORB_FIN = 2'd1;
  localparam logic [1:0] MODE_FINISH     = 2'd2;

  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned SCHED_WORDS = 16;
  localparam logic [5:0]  RND_LAST    = 6'd63;
  localparam logic [5:0]  POS_LAST    = 6'd63;
  localparam logic [5:0]  POS_LEN_PRE = 6'd55;
  localparam logic [2:0]  IDX_LAST    = 3'd7;
  localparam logic [7:0]  PAD_MARK    = 8'h80;

  typedef struct packed {
    logic       absorb;
    logic [7:0] data;
    logic       start;
    logic       reinit;
    logic [2:0] rd_idx;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
  } core_sts_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== rtl/shabs_core.sv =====
// Compression engine: hash words, 16-word block/schedule window, working variables,
// one shared round unit stepped by a round counter. Depends on shabs_pkg.
module shabs_core import shabs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  core_ctl_t   ctl,
  output core_sts_t   sts,
  output logic [31:0] rd_word
);

  logic [31:0] hash [HASH_WORDS];
  logic [31:0] w [SCHED_WORDS];
  logic [31:0] v [HASH_WORDS];
  logic [5:0]  rnd;
  logic        busy;
  logic        fin;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    w_new = w[0] + small_sig0(w[1]) + w[9] + small_sig1(w[14]);
    t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w[0];
    t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      rnd  <= '0;
    end else begin
      fin <= busy && (rnd == RND_LAST);
      if (ctl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == RND_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < HASH_WORDS; j++) begin
      if (rst || ctl.reinit) begin
        hash[j] <= init_hash(3'(j));
      end else if (fin) begin
        hash[j] <= hash[j] + v[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int j = 0; j < HASH_WORDS; j++) begin
        v[j] <= hash[j];
      end
    end else if (busy) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end
  end

  // shift bytes in big-endian while absorbing, shift words while rounds run
  always_ff @(posedge clk) begin
    if (ctl.absorb) begin
      for (int j = 0; j < SCHED_WORDS - 1; j++) begin
        w[j] <= {w[j][23:0], w[j+1][31:24]};
      end
      w[SCHED_WORDS-1] <= {w[SCHED_WORDS-1][23:0], ctl.data};
    end else if (busy) begin
      for (int j = 0; j < SCHED_WORDS - 1; j++) begin
        w[j] <= w[j+1];
      end
      w[SCHED_WORDS-1] <= w_new;
    end
  end

  assign sts.busy = busy | fin;
  assign rd_word  = hash[ctl.rd_idx];

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// Top level: byte intake, padding sequencer, byte counter and digest output.
// Depends on shabs_pkg and shabs_core.
//
//   channel  signals                               direction
//   msg      msg_valid msg_ready mode msg_byte     in
//   digest   digest_valid digest_ready             out
//            digest_word word_index last_word
//
// Each absorbed byte shifts into the block window; every 64th byte starts a
// compression (64 rounds of the single round unit, hash update, handoff).
// A finish runs the padding bytes and one or two compressions, then
// eight digest items. msg_ready is low from a finish until the last digest item
// is taken and during every compression; digest_ready stalls hold the sequencer.
// Reset loads the initial hash and clears the byte count.
module sha256_byte_stream_hasher import shabs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  msg_byte,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [63:0] count;
  logic [63:0] count_inc;
  logic [63:0] bit_len;
  logic        finishing;
  logic        mark_pending;
  logic        lenph;
  logic        pad_done;
  logic [2:0]  idx;
  logic [5:0]  pos;
  logic        take;
  logic        take_byte;
  logic        full;
  logic [7:0]  pad_byte;
  core_ctl_t   core_ctl;
  core_sts_t   core_sts;

  assign pos       = count[5:0];
  assign count_inc = count + 64'd1;
  assign take      = msg_valid && msg_ready;
  assign take_byte = take && (mode == MODE_ABSORB || mode == MODE_ABSORB_FIN);
  assign pad_byte  = mark_pending ? PAD_MARK :
                     lenph ? bit_len[{~pos[2:0], 3'b000} +: 8] : 8'h00;

  always_comb begin
    core_ctl.absorb = take_byte || (state == S_PAD);
    core_ctl.data   = (state == S_PAD) ? pad_byte : msg_byte;
    full            = core_ctl.absorb && (pos == POS_LAST);
    core_ctl.start  = full;
    core_ctl.reinit = digest_valid && digest_ready && (idx == IDX_LAST);
    core_ctl.rd_idx = idx;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          case (mode)
            MODE_ABSORB:     state_next = full ? S_COMP : S_IDLE;
            MODE_ABSORB_FIN: state_next = full ? S_COMP : S_PAD;
            MODE_FINISH:     state_next = S_PAD;
            default:         state_next = S_IDLE;
          endcase
        end
      end
      S_PAD: begin
        state_next = full ? S_COMP : S_PAD;
      end
      S_COMP: begin
        if (!core_sts.busy) begin
          state_next = pad_done ? S_OUT : (finishing ? S_PAD : S_IDLE);
        end
      end
      S_OUT: begin
        if (core_ctl.reinit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      finishing    <= 1'b0;
      mark_pending <= 1'b0;
      lenph        <= 1'b0;
      pad_done     <= 1'b0;
      idx          <= '0;
    end else begin
      state <= state_next;
      if (core_ctl.absorb) begin
        count <= count_inc;
      end
      if (take && (mode == MODE_ABSORB_FIN || mode == MODE_FINISH)) begin
        finishing    <= 1'b1;
        mark_pending <= 1'b1;
      end
      if (state == S_PAD) begin
        mark_pending <= 1'b0;
        if (!lenph && pos == POS_LEN_PRE) begin
          lenph <= 1'b1;
        end
        if (lenph && pos == POS_LAST) begin
          pad_done <= 1'b1;
        end
      end
      if (digest_valid && digest_ready) begin
        idx <= idx + 3'd1;
      end
      // drop message state once the final digest item is taken
      if (core_ctl.reinit) begin
        count     <= '0;
        finishing <= 1'b0;
        lenph     <= 1'b0;
        pad_done  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bit_len <= (mode == MODE_ABSORB_FIN) ? {count_inc[60:0], 3'b000}
                                           : {count[60:0], 3'b000};
    end
  end

  shabs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (core_ctl),
    .sts     (core_sts),
    .rd_word (digest_word)
  );

  assign msg_ready    = (state == S_IDLE);
  assign digest_valid = (state == S_OUT);
  assign word_index   = idx;
  assign last_word    = (idx == IDX_LAST);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && digest_valid))
    else $error("intake and digest output active together");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    core_ctl.start |-> !core_sts.busy)
    else $error("compression started while engine busy");

  a_pad_finishing: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD || state == S_OUT) |-> finishing)
    else $error("padding or output without a finish");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && last_word) |=> (msg_ready && count == 64'd0))
    else $error("state not restarted after final digest item");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for sha256_byte_stream_hasher: byte messages in, digest words out.
// Holds its own SHA-256 predictor and random handshake timing on both channels.
// Depends on shabs_pkg and the hasher RTL.
module tb;
  import shabs_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 460;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [255:0] IV_TABLE = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [2047:0] K_TABLE = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_ready;
  logic [1:0]  mode = MODE_ABSORB;
  logic [7:0]  msg_byte = 8'h00;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  msg_item_t    pending_items[$];
  digest_item_t expected_digest[$];

  logic [31:0] hash_h [8];
  logic [7:0]  blk_bytes [64];
  logic [63:0] byte_cnt;

  int msg_wait = 0;
  int msg_calm = 0;
  int dig_wait = 0;
  int dig_calm = 0;
  int error_cnt = 0;
  int cycle_cnt = 0;
  int accepted_cnt = 0;
  int items_total = 0;
  int items_counted = 0;

  sha256_byte_stream_hasher DUT (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .mode         (mode),
    .msg_byte     (msg_byte),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  initial forever #1 clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  task automatic sha_compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, s0, s1, t1, t2, w15, w2;
    int j, t;
    for (j = 0; j < 16; j++) begin
      w[j] = {blk_bytes[4*j], blk_bytes[4*j+1], blk_bytes[4*j+2], blk_bytes[4*j+3]};
    end
    for (j = 0; j < 8; j++) v[j] = hash_h[j];
    for (t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        w15 = w[(t - 15) & 15];
        w2  = w[(t - 2) & 15];
        s0  = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
        s1  = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
        wt  = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
        w[t & 15] = wt;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[(63 - t)*32 +: 32] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (j = 0; j < 8; j++) hash_h[j] = hash_h[j] + v[j];
  endtask

  task automatic start_message();
    int j;
    for (j = 0; j < 8; j++) hash_h[j] = IV_TABLE[(7 - j)*32 +: 32];
    byte_cnt = 64'd0;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    blk_bytes[byte_cnt[5:0]] = b;
    byte_cnt = byte_cnt + 64'd1;
    if (byte_cnt[5:0] == 6'd0) sha_compress();
  endtask

  task automatic apply_msg_item(input logic [1:0] m, input logic [7:0] b);
    logic [63:0]  bit_len;
    digest_item_t d;
    int k;
    if (m == MODE_ABSORB || m == MODE_ABSORB_FIN) absorb_byte(b);
    if (m == MODE_ABSORB_FIN || m == MODE_FINISH) begin
      bit_len = byte_cnt << 3;
      absorb_byte(PAD_MARK);
      while (byte_cnt[5:0] != 6'd56) absorb_byte(8'h00);
      for (k = 0; k < 8; k++) absorb_byte(bit_len[63 - 8*k -: 8]);
      for (k = 0; k < 8; k++) begin
        d.word = hash_h[k];
        d.idx  = k[2:0];
        d.last = (d.idx == IDX_LAST);
        expected_digest.push_back(d);
      end
      start_message();
    end
  endtask

  task automatic queue_item(input logic [1:0] m, input logic [7:0] b);
    msg_item_t it;
    it.mode = m;
    it.data = b;
    pending_items.push_back(it);
    if (m != MODE_UNUSED) items_counted++;
  endtask

  task automatic queue_message(input int len, input bit fin_with_byte);
    int i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0) queue_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
      if (fin_with_byte && i == len - 1) queue_item(MODE_ABSORB_FIN, 8'($urandom_range(0, 255)));
      else queue_item(MODE_ABSORB, 8'($urandom_range(0, 255)));
    end
    if (!fin_with_byte) queue_item(MODE_FINISH, 8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin : msg_driver
    logic v_nxt;
    msg_item_t it;
    if (rst) begin
      start_message();
      msg_valid <= 1'b0;
    end else begin
      v_nxt = msg_valid;
      if (msg_valid && msg_ready) begin
        apply_msg_item(mode, msg_byte);
        accepted_cnt++;
        v_nxt = 1'b0;
        if (msg_calm > 0) begin
          msg_calm--;
          msg_wait = 0;
        end else begin
          msg_wait = $urandom_range(0, 16);
          if ($urandom_range(0, 15) == 0) msg_calm = $urandom_range(20, 120);
        end
      end
      if (!v_nxt) begin
        if (msg_wait > 0) begin
          msg_wait--;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          mode     <= it.mode;
          msg_byte <= it.data;
          v_nxt = 1'b1;
        end
      end
      msg_valid <= v_nxt;
    end
  end

  always @(posedge clk) begin : digest_monitor
    logic r_nxt;
    digest_item_t exp_d;
    if (rst) begin
      digest_ready <= 1'b0;
    end else begin
      r_nxt = digest_ready;
      if (digest_valid && digest_ready) begin
        if (expected_digest.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("unexpected digest item: word %h index %0d last %b",
                     digest_word, word_index, last_word);
        end else begin
          exp_d = expected_digest.pop_front();
          if (digest_word !== exp_d.word || word_index !== exp_d.idx ||
              last_word !== exp_d.last) begin
            error_cnt++;
            if (error_cnt <= 10)
              $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       exp_d.word, exp_d.idx, exp_d.last,
                       digest_word, word_index, last_word);
          end
        end
        r_nxt = 1'b0;
        if (dig_calm > 0) begin
          dig_calm--;
          dig_wait = 0;
        end else begin
          dig_wait = $urandom_range(0, 16);
          if ($urandom_range(0, 7) == 0) dig_calm = $urandom_range(8, 40);
        end
      end
      if (!r_nxt) begin
        if (dig_wait > 0) dig_wait--;
        else r_nxt = 1'b1;
      end
      digest_ready <= r_nxt;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int rand_base, len, sel;
    bit fin_with_byte;

    queue_item(MODE_FINISH, 8'hff);
    queue_item(MODE_FINISH, 8'h00);
    queue_item(MODE_UNUSED, 8'hff);
    queue_item(MODE_UNUSED, 8'h00);
    queue_item(MODE_ABSORB, 8'h61);
    queue_item(MODE_ABSORB, 8'h62);
    queue_item(MODE_ABSORB_FIN, 8'h63);
    queue_item(MODE_ABSORB_FIN, 8'h00);
    queue_item(MODE_ABSORB_FIN, 8'hff);
    queue_item(MODE_ABSORB, 8'hff);
    queue_item(MODE_UNUSED, 8'h5a);
    queue_item(MODE_ABSORB, 8'h00);
    queue_item(MODE_FINISH, 8'h5a);

    rand_base = items_counted;
    while (items_counted - rand_base < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 11) begin
        len = $urandom_range(0, 10);
      end else if (sel < 16) begin
        case ($urandom_range(0, 7))
          0:       len = 55;
          1:       len = 56;
          2:       len = 57;
          3:       len = 63;
          4:       len = 64;
          5:       len = 65;
          6:       len = 119;
          default: len = 128;
        endcase
      end else begin
        len = $urandom_range(0, 140);
      end
      fin_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      queue_message(len, fin_with_byte);
    end
    items_total = pending_items.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (accepted_cnt < items_total) @(posedge clk);
    while (expected_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0 && expected_digest.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
